// File: hw/rtl/sliding_color_histogram_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding color histogram unit
// Shared property shapes so that every checking module reports the same way.
// ----------------------------------------------------------------------------
`ifndef SLIDING_COLOR_HISTOGRAM_UNIT_DEFINES_SVH
`define SLIDING_COLOR_HISTOGRAM_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SCH_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("sch invariant violated");

// A condition that must hold whenever a trigger holds.
`define SCH_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sch implication violated");

`endif

// File: hw/rtl/sch_pkg.sv
// ----------------------------------------------------------------------------
// Sliding color histogram package
// Command codes, decoded operations and the result word shared by all modules.
// ----------------------------------------------------------------------------
package sch_pkg;

   localparam int CMD_W   = 3;
   localparam int COLOR_W = 8;
   localparam int SUM_W   = 23;
   localparam int FRAC_W  = 16;
   localparam int PROB_W  = 17;

   localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START = 3'd1;
   localparam logic [CMD_W-1:0] CMD_END   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   localparam logic [COLOR_W-1:0] FULL_MASK = 8'hFF;
   localparam logic [SUM_W-1:0]   SUM_LIMIT = 23'h7FFFFF;
   localparam logic [PROB_W-1:0]  Q_ONE     = 17'h10000;

   typedef enum logic [2:0] {
      OP_PIXEL,
      OP_START,
      OP_END,
      OP_QUERY,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [SUM_W-1:0]  bin_count;
      logic [SUM_W-1:0]  total_pixels;
      logic [PROB_W-1:0] probability;
      logic              total_is_zero;
   } rsp_type;

endpackage

// File: hw/rtl/sch_front.sv
// ----------------------------------------------------------------------------
// Sliding color histogram front end
// Decodes commands, quantizes colors and holds a two-word queue for the engine.
// ----------------------------------------------------------------------------
module sch_front #(
   parameter int  BINS_PER_AXIS = 16,
   localparam int AXIS_CELLS    = 255 / BINS_PER_AXIS + 1,
   localparam int SLOT_CELLS    = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS,
   localparam int CELL_W        = (SLOT_CELLS > 1) ? $clog2(SLOT_CELLS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [sch_pkg::CMD_W-1:0]     command,
   input  logic [sch_pkg::COLOR_W-1:0]   red,
   input  logic [sch_pkg::COLOR_W-1:0]   green,
   input  logic [sch_pkg::COLOR_W-1:0]   blue,
   input  logic [sch_pkg::COLOR_W-1:0]   mask,
   output logic                          q_valid,
   output sch_pkg::op_type               q_op,
   output logic [CELL_W-1:0]             q_cell,
   input  logic                          q_pop
);
   localparam int AXIS_W     = (AXIS_CELLS > 1) ? $clog2(AXIS_CELLS) : 1;
   // Reciprocal scaled by 2^16; exact for 8-bit channels and divisors up to 256.
   localparam int RECIP      = (65536 + BINS_PER_AXIS - 1) / BINS_PER_AXIS;

   logic [24:0]       prod_r, prod_g, prod_b;
   logic              keep;
   sch_pkg::op_type   dec_op;
   logic              enq, deq;

   sch_pkg::op_type   op_ff [0:1];
   logic [AXIS_W-1:0] ri_ff [0:1];
   logic [AXIS_W-1:0] gi_ff [0:1];
   logic [AXIS_W-1:0] bi_ff [0:1];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;

   assign prod_r = 25'(red) * 25'(RECIP);
   assign prod_g = 25'(green) * 25'(RECIP);
   assign prod_b = 25'(blue) * 25'(RECIP);

   // Unused codes and unmasked pixels change nothing, so they never reach the queue.
   always_comb begin
      keep   = 1'b1;
      dec_op = sch_pkg::OP_PIXEL;
      unique case (command)
         sch_pkg::CMD_PIXEL: begin
            keep = (mask == sch_pkg::FULL_MASK);
         end
         sch_pkg::CMD_START: dec_op = sch_pkg::OP_START;
         sch_pkg::CMD_END:   dec_op = sch_pkg::OP_END;
         sch_pkg::CMD_QUERY: dec_op = sch_pkg::OP_QUERY;
         sch_pkg::CMD_CLEAR: dec_op = sch_pkg::OP_CLEAR;
         default:            keep   = 1'b0;
      endcase
   end

   assign full    = (count_ff == 2'd2);
   assign enq     = push && !full && keep;
   assign q_valid = (count_ff != 2'd0);
   assign deq     = q_pop && q_valid;
   assign q_op    = op_ff[rd_ptr_ff];
   assign q_cell  = CELL_W'(ri_ff[rd_ptr_ff]) * CELL_W'(AXIS_CELLS * AXIS_CELLS)
                  + CELL_W'(gi_ff[rd_ptr_ff]) * CELL_W'(AXIS_CELLS)
                  + CELL_W'(bi_ff[rd_ptr_ff]);

   always_ff @(posedge clock) begin
      if (enq) begin
         op_ff[wr_ptr_ff] <= dec_op;
         ri_ff[wr_ptr_ff] <= prod_r[16 +: AXIS_W];
         gi_ff[wr_ptr_ff] <= prod_g[16 +: AXIS_W];
         bi_ff[wr_ptr_ff] <= prod_b[16 +: AXIS_W];
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (enq) wr_ptr_ff <= !wr_ptr_ff;
         if (deq) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(enq) - 2'(deq);
      end
   end

endmodule

// File: hw/rtl/sch_engine.sv
// ----------------------------------------------------------------------------
// Sliding color histogram engine
// Owns the bin memory and frame state; executes one decoded operation at a time.
// ----------------------------------------------------------------------------
`include "sliding_color_histogram_unit_defines.svh"

module sch_engine #(
   parameter int  BINS_PER_AXIS    = 16,
   parameter int  HISTORY_DEPTH    = 8,
   parameter int  MAX_FRAME_PIXELS = 524288,
   localparam int AXIS_CELLS       = 255 / BINS_PER_AXIS + 1,
   localparam int SLOT_CELLS       = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS,
   localparam int CELL_W           = (SLOT_CELLS > 1) ? $clog2(SLOT_CELLS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  sch_pkg::op_type   q_op,
   input  logic [CELL_W-1:0] q_cell,
   output logic              q_pop,
   output logic              res_valid,
   output sch_pkg::rsp_type  res,
   input  logic              res_ready
);
   localparam int IDX_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
   localparam int CNT_W      = $clog2(MAX_FRAME_PIXELS + 1);
   localparam int ADD_W      = ((CNT_W > sch_pkg::SUM_W) ? CNT_W : sch_pkg::SUM_W) + 1;
   localparam int ADDR_W     = IDX_W + CELL_W;
   localparam int SW         = sch_pkg::SUM_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIX_WR,
      ST_CLR,
      ST_QRY,
      ST_DIV,
      ST_DONE
   } state_type;

   logic [CNT_W-1:0] bin_mem [0:(2**ADDR_W)-1];
   logic [CNT_W-1:0] cnt_mem [0:HISTORY_DEPTH-1];
   logic [CNT_W-1:0] bin_rd_ff, cnt_rd_ff;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  ring_ff, ring_in;
   logic [FILL_W-1:0] filled_ff, filled_in;
   logic [SW-1:0]     total_ff, total_in;
   logic              in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]  cur_cnt_ff, cur_cnt_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic [FILL_W-1:0] qslot_ff, qslot_in;
   logic              pend_ff, pend_in;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [sch_pkg::FRAC_W-1:0] quot_ff, quot_in;
   logic [3:0]        dcnt_ff, dcnt_in;
   logic [sch_pkg::PROB_W-1:0] prob_ff, prob_in;

   logic              bin_we, cnt_we;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic [ADD_W-1:0]  acc_sum, acc_total, old_cnt;
   logic [SW:0]       rem_dbl;

   // Slot counts outside the filled range read as zero, so the count memory needs no clear.
   assign old_cnt   = (filled_ff > FILL_W'(ring_ff)) ? ADD_W'(cnt_rd_ff) : '0;
   assign acc_sum   = ADD_W'(sum_ff) + ADD_W'(bin_rd_ff);
   assign acc_total = ADD_W'(total_ff) + ADD_W'(cur_cnt_ff);
   assign rem_dbl   = {rem_ff, 1'b0};

   always_comb begin
      state_in    = state_ff;
      ring_in     = ring_ff;
      filled_in   = filled_ff;
      total_in    = total_ff;
      in_frame_in = in_frame_ff;
      cur_cnt_in  = cur_cnt_ff;
      cell_in     = cell_ff;
      clr_in      = clr_ff;
      qslot_in    = qslot_ff;
      pend_in     = 1'b0;
      sum_in      = sum_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      dcnt_in     = dcnt_ff;
      prob_in     = prob_ff;
      q_pop       = 1'b0;
      bin_we      = 1'b0;
      cnt_we      = 1'b0;
      rd_addr     = {ring_ff, q_cell};
      wr_addr     = {ring_ff, cell_ff};
      wr_data     = bin_rd_ff + 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_op)
                  sch_pkg::OP_PIXEL: begin
                     cell_in = q_cell;
                     if (in_frame_ff && cur_cnt_ff < CNT_W'(MAX_FRAME_PIXELS)) begin
                        state_in = ST_PIX_WR;
                     end
                  end
                  sch_pkg::OP_START: begin
                     clr_in   = '0;
                     state_in = ST_CLR;
                  end
                  sch_pkg::OP_END: begin
                     if (in_frame_ff) begin
                        cnt_we      = 1'b1;
                        total_in    = (acc_total > ADD_W'(sch_pkg::SUM_LIMIT))
                                    ? sch_pkg::SUM_LIMIT : SW'(acc_total);
                        ring_in     = (ring_ff == IDX_W'(HISTORY_DEPTH - 1))
                                    ? '0 : ring_ff + 1'b1;
                        if (filled_ff < FILL_W'(HISTORY_DEPTH)) filled_in = filled_ff + 1'b1;
                        in_frame_in = 1'b0;
                     end
                  end
                  sch_pkg::OP_QUERY: begin
                     cell_in  = q_cell;
                     sum_in   = '0;
                     qslot_in = '0;
                     state_in = ST_QRY;
                  end
                  sch_pkg::OP_CLEAR: begin
                     ring_in     = '0;
                     filled_in   = '0;
                     total_in    = '0;
                     cur_cnt_in  = '0;
                     in_frame_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_PIX_WR: begin
            bin_we     = 1'b1;
            cur_cnt_in = cur_cnt_ff + 1'b1;
            state_in   = ST_IDLE;
         end
         ST_CLR: begin
            bin_we     = 1'b1;
            wr_addr    = {ring_ff, clr_ff};
            wr_data    = '0;
            cur_cnt_in = '0;
            clr_in     = clr_ff + 1'b1;
            // The slot's old count leaves the total once, when a new frame opens.
            if (clr_ff == '0 && !in_frame_ff) begin
               total_in = (ADD_W'(total_ff) > old_cnt) ? SW'(ADD_W'(total_ff) - old_cnt) : '0;
            end
            if (clr_ff == CELL_W'(SLOT_CELLS - 1)) begin
               in_frame_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_QRY: begin
            rd_addr = {qslot_ff[IDX_W-1:0], cell_ff};
            if (qslot_ff < filled_ff) begin
               pend_in  = 1'b1;
               qslot_in = qslot_ff + 1'b1;
            end
            if (pend_ff) begin
               sum_in = (acc_sum > ADD_W'(sch_pkg::SUM_LIMIT))
                      ? sch_pkg::SUM_LIMIT : SW'(acc_sum);
            end
            if (qslot_ff == filled_ff && !pend_ff) begin
               rem_in  = sum_ff;
               quot_in = '0;
               dcnt_in = '0;
               if (total_ff == '0) begin
                  prob_in  = '0;
                  state_in = ST_DONE;
               end else if (in_frame_ff || sum_ff >= total_ff) begin
                  prob_in  = sch_pkg::Q_ONE;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_dbl >= {1'b0, total_ff}) begin
               rem_in  = SW'(rem_dbl - {1'b0, total_ff});
               quot_in = {quot_ff[sch_pkg::FRAC_W-2:0], 1'b1};
            end else begin
               rem_in  = SW'(rem_dbl);
               quot_in = {quot_ff[sch_pkg::FRAC_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 4'(sch_pkg::FRAC_W - 1)) begin
               prob_in  = {1'b0, quot_in};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign res_valid           = (state_ff == ST_DONE);
   assign res.bin_count       = sum_ff;
   assign res.total_pixels    = total_ff;
   assign res.probability     = prob_ff;
   assign res.total_is_zero   = (total_ff == '0);

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[wr_addr] <= wr_data;
      bin_rd_ff <= bin_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[ring_ff] <= cur_cnt_ff;
      cnt_rd_ff <= cnt_mem[ring_ff];
   end

   always_ff @(posedge clock) begin
      cell_ff  <= cell_in;
      clr_ff   <= clr_in;
      qslot_ff <= qslot_in;
      sum_ff   <= sum_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      dcnt_ff  <= dcnt_in;
      prob_ff  <= prob_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         ring_ff     <= '0;
         filled_ff   <= '0;
         total_ff    <= '0;
         in_frame_ff <= 1'b0;
         cur_cnt_ff  <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ring_ff     <= ring_in;
         filled_ff   <= filled_in;
         total_ff    <= total_in;
         in_frame_ff <= in_frame_in;
         cur_cnt_ff  <= cur_cnt_in;
         pend_ff     <= pend_in;
      end
   end

   `SCH_ASSERT_ALWAYS(a_filled_bound, clock, reset, filled_ff <= FILL_W'(HISTORY_DEPTH))
   `SCH_ASSERT_ALWAYS(a_ring_bound, clock, reset, ring_ff <= IDX_W'(HISTORY_DEPTH - 1))
   `SCH_ASSERT_IMPLY(a_zero_prob, clock, reset, res_valid && res.total_is_zero, res.probability == '0)
   `SCH_ASSERT_IMPLY(a_pix_count, clock, reset, $past(state_ff == ST_PIX_WR) && !$past(reset), cur_cnt_ff == $past(cur_cnt_ff) + 1'b1)

endmodule

// File: hw/rtl/sliding_color_histogram_unit.sv
// ----------------------------------------------------------------------------
// Sliding color histogram unit
// Color histograms of the most recent frames in a ring, with bin queries.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Words carried
//  req_      req_push/req_full   command, red, green, blue, mask
//  rsp_      rsp_pop/rsp_empty   bin_count, total_pixels, probability, total_is_zero
//
//  A counted pixel is a bin read, then a write back; pixels with a partial
//  mask and unused codes never reach the engine; pixels outside a frame or past
//  the frame cap, end_frame and the reset command are handled in the idle state.
//  A start_frame sweeps the slot's (255/BINS_PER_AXIS+1)^3 bins, one per cycle.
//  A query sums the bin over the filled slots and may then run the divider.
//  A two-word queue separates decode from the engine; a full result register
//  stalls the engine but lets the queue keep filling. Reset is synchronous.
module sliding_color_histogram_unit #(
   parameter int BINS_PER_AXIS    = 16,
   parameter int HISTORY_DEPTH    = 8,
   parameter int MAX_FRAME_PIXELS = 524288
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [sch_pkg::CMD_W-1:0]          req_command,
   input  logic [sch_pkg::COLOR_W-1:0]        req_red,
   input  logic [sch_pkg::COLOR_W-1:0]        req_green,
   input  logic [sch_pkg::COLOR_W-1:0]        req_blue,
   input  logic [sch_pkg::COLOR_W-1:0]        req_mask,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sch_pkg::SUM_W-1:0]          rsp_bin_count,
   output logic [sch_pkg::SUM_W-1:0]          rsp_total_pixels,
   output logic [sch_pkg::PROB_W-1:0]         rsp_probability,
   output logic                               rsp_total_is_zero
);
   localparam int AXIS_CELLS = 255 / BINS_PER_AXIS + 1;
   localparam int SLOT_CELLS = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;
   localparam int CELL_W     = (SLOT_CELLS > 1) ? $clog2(SLOT_CELLS) : 1;

   logic              q_valid, q_pop;
   sch_pkg::op_type   q_op;
   logic [CELL_W-1:0] q_cell;
   logic              res_valid, res_ready;
   sch_pkg::rsp_type  res;
   sch_pkg::rsp_type  out_ff;
   logic              out_valid_ff;

   sch_front #(
      .BINS_PER_AXIS (BINS_PER_AXIS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .command (req_command),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .mask    (req_mask),
      .q_valid (q_valid),
      .q_op    (q_op),
      .q_cell  (q_cell),
      .q_pop   (q_pop)
   );

   sch_engine #(
      .BINS_PER_AXIS    (BINS_PER_AXIS),
      .HISTORY_DEPTH    (HISTORY_DEPTH),
      .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .q_cell    (q_cell),
      .q_pop     (q_pop),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // The result register takes a new word whenever it is empty or being drained.
   assign res_ready = !out_valid_ff || rsp_pop;

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) out_ff <= res;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_bin_count     = out_ff.bin_count;
   assign rsp_total_pixels  = out_ff.total_pixels;
   assign rsp_probability   = out_ff.probability;
   assign rsp_total_is_zero = out_ff.total_is_zero;

endmodule

// File: test/tb_sliding_color_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding color histogram unit testbench
// Sends framed pixel streams, bin queries and control words through the request
// queue and compares every query result with a typed answer or with a behavioral
// histogram ring kept in the bench. Both sides of the block idle in random bursts.
// ----------------------------------------------------------------------------
module tb_sliding_color_histogram_unit;

   localparam int BINS          = 16;
   localparam int DEPTH         = 8;
   localparam int FRAME_CAP     = 524288;
   localparam int AXIS          = 255 / BINS + 1;
   localparam int CELLS         = AXIS * AXIS * AXIS;
   localparam int ITEM_TARGET   = 450;
   // A start_frame sweeps 4096 bins; two more can sit queued behind one in progress.
   localparam int STALL_LIMIT   = 60000;
   localparam int DRAIN_CYCLES  = 60;
   localparam logic [sch_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [sch_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_push = 1'b0;
   logic                         req_full;
   logic [sch_pkg::CMD_W-1:0]    req_command = sch_pkg::CMD_PIXEL;
   logic [sch_pkg::COLOR_W-1:0]  req_red = '0, req_green = '0, req_blue = '0, req_mask = '0;
   logic                         rsp_empty;
   logic                         rsp_pop = 1'b0;
   logic [sch_pkg::SUM_W-1:0]    rsp_bin_count, rsp_total_pixels;
   logic [sch_pkg::PROB_W-1:0]   rsp_probability;
   logic                         rsp_total_is_zero;

   sliding_color_histogram_unit u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Behavioral copy of the histogram ring.
   logic [19:0] hist_bins [DEPTH*CELLS];
   logic [19:0] slot_pixels [DEPTH];
   logic [sch_pkg::SUM_W-1:0] stored_total;
   int unsigned      slot_ptr;
   int unsigned      slots_filled;
   bit               frame_open;

   sch_pkg::rsp_type pending_answers [$];
   int      mismatches = 0;
   int      items_sent = 0;
   bit      quiet_phase = 0;

   function automatic int unsigned bin_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return ((r / BINS) * AXIS + (g / BINS)) * AXIS + (b / BINS);
   endfunction

   function automatic logic [sch_pkg::SUM_W-1:0] add_clamped(logic [sch_pkg::SUM_W-1:0] a,
                                                             longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > sch_pkg::SUM_LIMIT) ? sch_pkg::SUM_LIMIT : s[sch_pkg::SUM_W-1:0];
   endfunction

   // Applies one accepted word to the ring and returns the answer of a query.
   function automatic bit histogram_update(logic [2:0] cmd, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b, logic [7:0] m,
                                           output sch_pkg::rsp_type answer);
      int unsigned bin_idx, base;
      logic [sch_pkg::SUM_W-1:0] sum;
      bin_idx = bin_of(r, g, b);
      base = slot_ptr * CELLS;
      answer = '0;
      case (cmd)
         sch_pkg::CMD_PIXEL: begin
            if (frame_open && m == sch_pkg::FULL_MASK &&
                slot_pixels[slot_ptr] < FRAME_CAP) begin
               hist_bins[base + bin_idx]++;
               slot_pixels[slot_ptr]++;
            end
         end
         sch_pkg::CMD_START: begin
            if (!frame_open)
               stored_total = (stored_total > slot_pixels[slot_ptr]) ?
                              stored_total - slot_pixels[slot_ptr] : '0;
            for (int i = 0; i < CELLS; i++) hist_bins[base + i] = '0;
            slot_pixels[slot_ptr] = '0;
            frame_open = 1;
         end
         sch_pkg::CMD_END: begin
            if (frame_open) begin
               stored_total = add_clamped(stored_total, slot_pixels[slot_ptr]);
               slot_ptr = (slot_ptr + 1 >= DEPTH) ? 0 : slot_ptr + 1;
               if (slots_filled < DEPTH) slots_filled++;
               frame_open = 0;
            end
         end
         sch_pkg::CMD_QUERY: begin
            sum = '0;
            for (int s = 0; s < slots_filled; s++)
               sum = add_clamped(sum, hist_bins[s * CELLS + bin_idx]);
            answer.bin_count = sum;
            answer.total_pixels = stored_total;
            answer.total_is_zero = (stored_total == 0);
            if (stored_total == 0)
               answer.probability = '0;
            else if (frame_open || sum >= stored_total)
               answer.probability = sch_pkg::Q_ONE;
            else
               answer.probability = sch_pkg::PROB_W'((64'(sum) << sch_pkg::FRAC_W)
                                                     / stored_total);
            return 1;
         end
         sch_pkg::CMD_CLEAR: begin
            slot_ptr = 0;
            slots_filled = 0;
            stored_total = '0;
            for (int i = 0; i < DEPTH; i++) slot_pixels[i] = '0;
            frame_open = 0;
         end
         default: ;
      endcase
      return 0;
   endfunction

   // Sends one word; an optional typed answer replaces the computed one.
   task automatic send_word(logic [2:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] m, bit typed = 0,
                            sch_pkg::rsp_type typed_answer = '0);
      sch_pkg::rsp_type answer;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_command = cmd;
      req_red = r;
      req_green = g;
      req_blue = b;
      req_mask = m;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      if (histogram_update(cmd, r, g, b, m, answer))
         pending_answers.push_back(typed ? typed_answer : answer);
      items_sent++;
      @(negedge clock);
   endtask

   // Result side: pop bursts with random holds, then steady popping at the end.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (quiet_phase) begin
            rsp_pop = 1'b1;
         end else if (hold > 0) begin
            rsp_pop = 1'b0;
            hold--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_pop = 1'b0;
            hold = $urandom_range(1, 18) - 1;
         end else begin
            rsp_pop = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      sch_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: bin %0d total %0d prob %0d zero %0d",
                        rsp_bin_count, rsp_total_pixels, rsp_probability, rsp_total_is_zero);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bin_count !== want.bin_count || rsp_total_pixels !== want.total_pixels ||
                rsp_probability !== want.probability ||
                rsp_total_is_zero !== want.total_is_zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           want.bin_count, want.total_pixels, want.probability,
                           want.total_is_zero, rsp_bin_count, rsp_total_pixels,
                           rsp_probability, rsp_total_is_zero);
            end
         end
      end
   end

   // The watchdog ends the run when no word moves for too long.
   always @(posedge clock) begin
      static int idle_cycles = 0;
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_sliding_color_histogram_unit NOT OK");
         $finish;
      end
   end

   typedef struct {
      logic [2:0]       cmd;
      logic [7:0]       r, g, b, m;
      bit               typed;
      sch_pkg::rsp_type want;
   } plan_row;

   function automatic plan_row mk(logic [2:0] cmd, logic [7:0] r, logic [7:0] g,
                                  logic [7:0] b, logic [7:0] m, bit typed = 0,
                                  logic [sch_pkg::SUM_W-1:0] bc = 0,
                                  logic [sch_pkg::SUM_W-1:0] tp = 0,
                                  logic [sch_pkg::PROB_W-1:0] pr = 0, logic z = 0);
      plan_row row;
      row.cmd = cmd; row.r = r; row.g = g; row.b = b; row.m = m; row.typed = typed;
      row.want.bin_count = bc;
      row.want.total_pixels = tp;
      row.want.probability = pr;
      row.want.total_is_zero = z;
      return row;
   endfunction

   initial begin
      plan_row plan [$];
      logic [7:0] palette [4][3];
      int pick, npix;

      for (int i = 0; i < DEPTH*CELLS; i++) hist_bins[i] = '0;
      for (int i = 0; i < DEPTH; i++) slot_pixels[i] = '0;
      stored_total = '0;
      slot_ptr = 0;
      slots_filled = 0;
      frame_open = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Answers with an obvious value are typed in, the rest
      // come from the bench's own histogram.
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 1));
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'h10, 8'h20, 8'h30, 8'hFF)); // outside a frame
      plan.push_back(mk(sch_pkg::CMD_END, 8'h00, 8'h00, 8'h00, 8'h00));   // outside a frame
      plan.push_back(mk(sch_pkg::CMD_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF));
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'h0F, 8'h0F, 8'h0F, 8'hFE)); // mask not full
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'h0F, 8'h0F, 8'h0F, 8'hFF));
      // Inside the first frame nothing is filled yet and the total is zero.
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 1));
      plan.push_back(mk(sch_pkg::CMD_END, 8'hAA, 8'h55, 8'hAA, 8'h55));
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00));
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'h00));
      plan.push_back(mk(CMD_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      plan.push_back(mk(CMD_SPARE_HI, 8'h00, 8'h00, 8'h00, 8'h00));
      plan.push_back(mk(sch_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h00));
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'hF0, 8'h0F, 8'hF0, 8'hFF));
      plan.push_back(mk(sch_pkg::CMD_START, 8'h00, 8'h00, 8'h00, 8'h00)); // restart the frame
      plan.push_back(mk(sch_pkg::CMD_PIXEL, 8'hF0, 8'h0F, 8'hF0, 8'hFF));
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'hF0, 8'h0F, 8'hF0, 8'h00)); // inside a frame
      plan.push_back(mk(sch_pkg::CMD_END, 8'h00, 8'h00, 8'h00, 8'h00));
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'hF0, 8'h0F, 8'hF0, 8'h00));
      plan.push_back(mk(sch_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
      plan.push_back(mk(sch_pkg::CMD_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0, 0, 1));
      foreach (plan[i])
         send_word(plan[i].cmd, plan[i].r, plan[i].g, plan[i].b, plan[i].m,
                   plan[i].typed, plan[i].want);

      // Random part: mostly well-formed frames over a small palette so that
      // queried bins hold real counts, with noise words mixed in.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET * 85 / 100) quiet_phase = 1;
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 3; k++)
               palette[c][k] = {$urandom_range(0, 3) == 0 ? 4'($urandom)
                                                         : 4'($urandom_range(0, 2)),
                                4'($urandom)};
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_word(sch_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
         end else if (pick < 3) begin
            send_word(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
         end else begin
            if (pick == 3)
               send_word(sch_pkg::CMD_END, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            send_word(sch_pkg::CMD_START, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
            npix = $urandom_range(1, 12);
            for (int p = 0; p < npix; p++) begin
               pick = $urandom_range(0, 3);
               if ($urandom_range(0, 9) == 0)
                  send_word(sch_pkg::CMD_QUERY, palette[pick][0], palette[pick][1],
                            palette[pick][2], 8'($urandom));
               else if ($urandom_range(0, 9) == 0)
                  send_word(sch_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                            $urandom_range(0, 1) ? sch_pkg::FULL_MASK : 8'($urandom));
               else
                  send_word(sch_pkg::CMD_PIXEL, palette[pick][0], palette[pick][1],
                            palette[pick][2], sch_pkg::FULL_MASK);
            end
            if ($urandom_range(0, 7) != 0)
               send_word(sch_pkg::CMD_END, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            repeat ($urandom_range(1, 3)) begin
               pick = $urandom_range(0, 3);
               send_word(sch_pkg::CMD_QUERY, palette[pick][0] ^ 8'($urandom_range(0, 15)),
                         palette[pick][1], palette[pick][2], 8'($urandom));
            end
         end
      end
      req_push = 1'b0;

      wait (pending_answers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("tb_sliding_color_histogram_unit OK");
      else
         $display("tb_sliding_color_histogram_unit NOT OK");
      $finish;
   end

endmodule
